[hdl/ctpd_pkg.sv]
// ----------------------------------------------------------------------------
// ctpd_pkg
// Types and constants shared by the curve turning point detector modules.
// ----------------------------------------------------------------------------
`default_nettype none

package ctpd_pkg;

    localparam int COORD_BITS = 12;
    localparam int COUNT_BITS = 8;

    localparam logic [COUNT_BITS-1:0] THRESHOLD_RESET = COUNT_BITS'(10);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX       = {COUNT_BITS{1'b1}};

    // sweep direction codes
    localparam logic [1:0] DIR_UNDECIDED = 2'd0;
    localparam logic [1:0] DIR_RIGHT     = 2'd1;
    localparam logic [1:0] DIR_LEFT      = 2'd2;

    // extreme kinds
    localparam logic KIND_MAX = 1'b0;
    localparam logic KIND_MIN = 1'b1;

    typedef struct packed {
        logic [COORD_BITS-1:0] point_x;
        logic [COORD_BITS-1:0] point_y;
        logic                  start_of_curve;
    } t_point_in;

    typedef struct packed {
        logic [COORD_BITS-1:0] extreme_x;
        logic [COORD_BITS-1:0] extreme_y;
        logic                  extreme_kind;
    } t_extreme;

    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
    } t_pt;

endpackage

`default_nettype wire

[hdl/curve_turning_point_detector.sv]
// ----------------------------------------------------------------------------
// curve_turning_point_detector
// Finds turning points of a curve from its x sweep direction, with hysteresis.
// ----------------------------------------------------------------------------
//  channel   dir  handshake                  payload
//  in        in   i_in_valid / o_in_stall    i_in_data  (t_point_in)
//  out       out  o_out_valid / i_out_stall  o_out_data (t_extreme)
//  cfg       in   i_cfg_we                   i_cfg_wdata (turn threshold)
//
//  One point per cycle while o_in_stall is low; the state update is a compare
//  and a counter step; each confirmed turn is registered in the output buffer.
//  The result register plus one skid entry keep the input open while a
//  result waits; the input stalls only when both are occupied.
//  Synchronous active-low reset; threshold resets to 10.
// ----------------------------------------------------------------------------
`default_nettype none

module curve_turning_point_detector
    import ctpd_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [COUNT_BITS-1:0] i_cfg_wdata,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire t_point_in             i_in_data,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output t_extreme                   o_out_data
);

    logic     accept;
    logic     res_valid;
    t_extreme res;
    logic     buf_full;

    assign o_in_stall = buf_full;
    assign accept     = i_in_valid && !buf_full;

    ctpd_tracker u_tracker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (accept),
        .i_point     (i_in_data),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    ctpd_out_buf u_out_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .i_res       (res),
        .o_full      (buf_full),
        .o_valid     (o_out_valid),
        .i_stall     (i_out_stall),
        .o_data      (o_out_data)
    );

endmodule

`default_nettype wire

[hdl/ctpd_tracker.sv]
// ----------------------------------------------------------------------------
// ctpd_tracker
// Sweep direction tracking with hysteresis counter; one point per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module ctpd_tracker
    import ctpd_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [COUNT_BITS-1:0] i_cfg_wdata,
    input  wire logic                  i_accept,
    input  wire t_point_in             i_point,
    output logic                       o_res_valid,
    output t_extreme                   o_res
);

    logic [COUNT_BITS-1:0] r_threshold;
    logic [1:0]            r_dir,  n_dir;
    logic [COUNT_BITS-1:0] r_cnt,  n_cnt;
    logic [COORD_BITS-1:0] r_prev, n_prev;
    t_pt                   r_max,  n_max;
    t_pt                   r_min,  n_min;

    logic [COUNT_BITS-1:0] bumped;
    logic                  exceeded;
    t_pt                   cur;

    assign cur      = '{x: i_point.point_x, y: i_point.point_y};
    // counter saturates, so a threshold at the top never confirms a change
    assign bumped   = (r_cnt == COUNT_MAX) ? r_cnt : r_cnt + 1'b1;
    assign exceeded = bumped > r_threshold;

    always_comb begin
        n_dir       = r_dir;
        n_cnt       = r_cnt;
        n_prev      = i_point.point_x;
        n_max       = r_max;
        n_min       = r_min;
        o_res_valid = 1'b0;
        o_res       = '0;
        if (i_point.start_of_curve) begin
            n_dir = DIR_UNDECIDED;
            n_cnt = '0;
            n_max = '0;
            n_min = '0;
        end else if (i_point.point_x > r_prev) begin
            case (r_dir)
                DIR_RIGHT: begin
                    n_cnt = '0;
                    n_max = cur;
                end
                DIR_LEFT: begin
                    n_cnt = bumped;
                    if (exceeded) begin
                        n_cnt        = '0;
                        n_dir        = DIR_RIGHT;
                        o_res_valid  = 1'b1;
                        o_res.extreme_x    = r_min.x;
                        o_res.extreme_y    = r_min.y;
                        o_res.extreme_kind = KIND_MIN;
                    end
                end
                default: begin
                    n_cnt = bumped;
                    if (exceeded) begin
                        n_cnt = '0;
                        n_dir = DIR_RIGHT;
                    end
                end
            endcase
        end else if (i_point.point_x < r_prev) begin
            case (r_dir)
                DIR_LEFT: begin
                    n_cnt = '0;
                    n_min = cur;
                end
                DIR_RIGHT: begin
                    n_cnt = bumped;
                    if (exceeded) begin
                        n_cnt        = '0;
                        n_dir        = DIR_LEFT;
                        o_res_valid  = 1'b1;
                        o_res.extreme_x    = r_max.x;
                        o_res.extreme_y    = r_max.y;
                        o_res.extreme_kind = KIND_MAX;
                    end
                end
                default: begin
                    n_cnt = bumped;
                    if (exceeded) begin
                        n_cnt = '0;
                        n_dir = DIR_LEFT;
                    end
                end
            endcase
        end
        // result only counts for an accepted transaction
        if (!i_accept) begin
            o_res_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESHOLD_RESET;
        end else if (i_cfg_we) begin
            r_threshold <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir  <= DIR_UNDECIDED;
            r_cnt  <= '0;
            r_prev <= '0;
            r_max  <= '0;
            r_min  <= '0;
        end else if (i_accept) begin
            r_dir  <= n_dir;
            r_cnt  <= n_cnt;
            r_prev <= n_prev;
            r_max  <= n_max;
            r_min  <= n_min;
        end
    end

endmodule

`default_nettype wire

[hdl/ctpd_out_buf.sv]
// ----------------------------------------------------------------------------
// ctpd_out_buf
// Result register with one skid entry; stalls upstream only when the skid fills.
// ----------------------------------------------------------------------------
`default_nettype none

module ctpd_out_buf
    import ctpd_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_res_valid,
    input  wire t_extreme i_res,
    output logic          o_full,
    output logic          o_valid,
    input  wire logic     i_stall,
    output t_extreme      o_data
);

    logic     r_out_valid, n_out_valid;
    logic     r_skid_valid, n_skid_valid;
    t_extreme r_out, n_out;
    t_extreme r_skid, n_skid;
    logic     out_fire;

    assign out_fire = r_out_valid && !i_stall;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (r_skid_valid) begin
            // upstream is held off while the skid entry is occupied
            if (out_fire) begin
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end
        end else if (!r_out_valid || out_fire) begin
            n_out_valid = i_res_valid;
            n_out       = i_res;
        end else if (i_res_valid) begin
            n_skid_valid = 1'b1;
            n_skid       = i_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_full  = r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

`default_nettype wire

[hdl/ctpd_checker.sv]
// ----------------------------------------------------------------------------
// ctpd_checker
// Port-level checks for the curve turning point detector.
// ----------------------------------------------------------------------------
`default_nettype none

module ctpd_checker
    import ctpd_pkg::*;
(
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  i_in_valid,
    input wire logic                  o_in_stall,
    input wire t_point_in             i_in_data,
    input wire logic                  o_out_valid,
    input wire logic                  i_out_stall,
    input wire t_extreme              o_out_data
);

    // nothing pending right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("output not empty after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output valid dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_data))
        else $error("output payload changed while stalled");

    // input backpressure only when a result already sits in the output
    a_stall_needs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with empty output");

    // a start point never produces a result
    a_start_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_in_data.start_of_curve && !o_out_valid
        |=> !o_out_valid)
        else $error("result after start-of-curve transaction");

endmodule

bind curve_turning_point_detector ctpd_checker u_ctpd_checker (.*);

`default_nettype wire
